// ===== src/afcp_pkg.sv =====
// Package for the ASCII frame checksum parser.
// Holds the transaction types, character codes, status codes and parser phases.
// It depends on nothing else.
`default_nettype none

package afcp_pkg;

   // Default for the largest field index plus one.
   localparam int MaxFieldsDefault = 64;

   // Number of result slots in the output queue.
   localparam int OutqDepth = 4;

   // Character codes.
   localparam logic [7:0] CharStart  = 8'h53;  // 'S'
   localparam logic [7:0] CharEnd    = 8'h45;  // 'E'
   localparam logic [7:0] CharCheck  = 8'h43;  // 'C'
   localparam logic [7:0] CharVerify = 8'h56;  // 'V'
   localparam logic [7:0] CharComma  = 8'h2C;  // ','
   localparam logic [7:0] CharZero   = 8'h30;  // '0'
   localparam logic [7:0] CharNine   = 8'h39;  // '9'

   // Result kinds.
   localparam logic KindField   = 1'b0;
   localparam logic KindVerdict = 1'b1;

   // Frame verdict codes.
   localparam logic [1:0] StatusOk        = 2'd0;
   localparam logic [1:0] StatusNoEnd     = 2'd1;
   localparam logic [1:0] StatusNoFields  = 2'd2;
   localparam logic [1:0] StatusMismatch  = 2'd3;

   typedef enum logic [2:0] {
      PH_WAIT,
      PH_FIELDS,
      PH_AFTER_E,
      PH_CHECK,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic        item_kind;
      logic [5:0]  field_index;
      logic [15:0] field_value;
      logic [1:0]  frame_status;
      logic [6:0]  fields_seen;
      logic        last_result;
   } rsp_type;

   // Results produced by one accepted character, in delivery order.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

`default_nettype wire

// ===== src/afcp_if.sv =====
// Valid/ready channel interfaces for the ASCII frame checksum parser.
// Depends on afcp_pkg for the payload types.
`default_nettype none

interface afcp_req_if;
   import afcp_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface afcp_rsp_if;
   import afcp_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/ascii_frame_checksum_parser.sv =====
// Top level of the ASCII frame checksum parser.
// Depends on afcp_pkg, afcp_if, afcp_parse and afcp_outq.
`default_nettype none

// Channel    Direction  Transaction
// req_chan   in         one character: char_code, end_of_string
// rsp_chan   out        one result: field (index, value) or frame verdict
// csr_*      in         write of skip_first_in_sum, no read-back
//
// One character is taken per clock while ready, and its results enter a four-slot queue
// at the same edge, so they are offered from registered slots. A character that yields
// two results (a field closed by ',' or 'E' on the last character, then the verdict)
// goes out as two transactions; the input is ready while at most two slots are in use.
// Reset is synchronous and active high; it empties the queue, clears the parser and
// sets skip_first_in_sum to 1. A stall on rsp_chan stalls req_chan once three slots fill.

module ascii_frame_checksum_parser #(
   parameter int MAX_FIELDS = afcp_pkg::MaxFieldsDefault
) (
   input  wire logic   clock,
   input  wire logic   reset,
   afcp_req_if.sink    req_chan,
   afcp_rsp_if.source  rsp_chan,
   input  wire logic   csr_wr_en,
   input  wire logic   csr_wr_data
);
   import afcp_pkg::*;

   // Mode register: when set, field 0 (the address) is left out of the sum.
   logic     skip_first_ff, skip_first_in;
   logic     room;
   logic     accept;
   push_type push;

   assign skip_first_in = csr_wr_en ? csr_wr_data : skip_first_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_first_ff <= 1'b1;
      end else begin
         skip_first_ff <= skip_first_in;
      end
   end

   // A character is accepted whenever the queue can take the two results it may
   // produce; the parser then writes its results in the same cycle.
   assign req_chan.ready = room;
   assign accept         = req_chan.valid && room;

   afcp_parse #(
      .MAX_FIELDS (MAX_FIELDS)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_data   (req_chan.data),
      .skip_first (skip_first_ff),
      .push       (push)
   );

   afcp_outq u_outq (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .room     (room),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== src/afcp_parse.sv =====
// Per-character frame parser: phase state machine, field and checksum accumulators.
// Depends on afcp_pkg; produces up to two results per accepted character.
`default_nettype none

module afcp_parse #(
   parameter int MAX_FIELDS = afcp_pkg::MaxFieldsDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  afcp_pkg::req_type       req_data,
   input  wire logic               skip_first,
   output afcp_pkg::push_type      push
);
   import afcp_pkg::*;

   localparam int CountCap = (MAX_FIELDS < 127) ? MAX_FIELDS : 127;
   localparam int IdxMax   = MAX_FIELDS - 1;

   phase_type   phase_ff, phase_in, phase_step;
   logic [15:0] accum_ff, accum_in;
   logic [6:0]  low_ff, low_in;
   logic        has_ff, has_in;
   logic        bad_ff, bad_in;
   logic [6:0]  count_ff, count_in, count_step;
   logic [6:0]  sum_ff, sum_in, sum_step;
   logic [6:0]  check_ff, check_in, check_step;
   logic        cbad_ff, cbad_in, cbad_step;

   logic [7:0]  c;
   logic        eos;
   logic        digit;
   logic [3:0]  d;
   logic        is_sep;
   logic        fld_fire;
   logic [19:0] accum_mul;
   logic [15:0] accum_sat;
   logic [10:0] low_mul;
   logic [10:0] check_mul;
   logic [8:0]  count_ext;
   logic [8:0]  idx_full;
   logic [6:0]  field_low;
   logic [6:0]  chk_final;
   logic [1:0]  status;
   rsp_type     field_rsp;
   rsp_type     verdict_rsp;

   assign c      = req_data.char_code;
   assign eos    = req_data.end_of_string;
   assign digit  = (c >= CharZero) && (c <= CharNine);
   assign d      = digit ? 4'(c - CharZero) : 4'd0;
   assign is_sep = (c == CharComma) || (c == CharEnd);

   assign accum_mul = {4'd0, accum_ff} * 20'd10 + {16'd0, d};
   assign accum_sat = (accum_mul > 20'd65535) ? 16'hFFFF : accum_mul[15:0];
   assign low_mul   = {4'd0, low_ff} * 11'd10 + {7'd0, d};
   assign check_mul = {4'd0, check_ff} * 11'd10 + {7'd0, d};

   assign fld_fire  = accept && (phase_ff == PH_FIELDS) && is_sep && has_ff;
   assign field_low = bad_ff ? 7'd0 : low_ff;
   assign count_ext = {2'd0, count_ff};
   assign idx_full  = (count_ext < 9'(IdxMax)) ? count_ext : 9'(IdxMax);

   // Next state.
   always_comb begin
      phase_step = phase_ff;
      accum_in   = accum_ff;
      low_in     = low_ff;
      has_in     = has_ff;
      bad_in     = bad_ff;
      count_step = count_ff;
      sum_step   = sum_ff;
      check_step = check_ff;
      cbad_step  = cbad_ff;
      case (phase_ff)
         PH_WAIT: begin
            if (c == CharStart) phase_step = PH_FIELDS;
         end
         PH_FIELDS: begin
            if (is_sep) begin
               if (has_ff) begin
                  if (!(skip_first && count_ff == 7'd0)) sum_step = sum_ff + field_low;
                  if ({2'd0, count_ff} < 9'(CountCap)) count_step = count_ff + 7'd1;
                  accum_in = '0;
                  low_in   = '0;
                  has_in   = 1'b0;
                  bad_in   = 1'b0;
               end
               if (c == CharEnd) phase_step = PH_AFTER_E;
            end else begin
               has_in = 1'b1;
               if (digit) begin
                  accum_in = accum_sat;
                  low_in   = low_mul[6:0];
               end else begin
                  bad_in = 1'b1;
               end
            end
         end
         PH_AFTER_E: begin
            if (c == CharCheck) phase_step = PH_CHECK;
         end
         PH_CHECK: begin
            if (c == CharVerify) phase_step = PH_DONE;
            else if (digit) check_step = check_mul[6:0];
            else cbad_step = 1'b1;
         end
         default: begin
         end
      endcase

      // The verdict closes the frame and clears everything.
      phase_in = phase_step;
      count_in = count_step;
      sum_in   = sum_step;
      check_in = check_step;
      cbad_in  = cbad_step;
      if (eos) begin
         phase_in = PH_WAIT;
         accum_in = '0;
         low_in   = '0;
         has_in   = 1'b0;
         bad_in   = 1'b0;
         count_in = '0;
         sum_in   = '0;
         check_in = '0;
         cbad_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         accum_ff <= '0;
         low_ff   <= '0;
         has_ff   <= 1'b0;
         bad_ff   <= 1'b0;
         count_ff <= '0;
         sum_ff   <= '0;
         check_ff <= '0;
         cbad_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         accum_ff <= accum_in;
         low_ff   <= low_in;
         has_ff   <= has_in;
         bad_ff   <= bad_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         check_ff <= check_in;
         cbad_ff  <= cbad_in;
      end
   end

   // Verdict, judged on the state after this character.
   assign chk_final = cbad_step ? 7'd0 : check_step;

   always_comb begin
      if (phase_step == PH_WAIT || phase_step == PH_FIELDS) begin
         status = StatusNoEnd;
      end else if (count_step == 7'd0) begin
         status = StatusNoFields;
      end else if (phase_step == PH_CHECK || phase_step == PH_DONE) begin
         status = (chk_final != sum_step) ? StatusMismatch : StatusOk;
      end else begin
         status = StatusOk;
      end
   end

   // Outputs.
   always_comb begin
      field_rsp              = '0;
      field_rsp.item_kind    = KindField;
      field_rsp.field_index  = idx_full[5:0];
      field_rsp.field_value  = bad_ff ? 16'd0 : accum_ff;
      field_rsp.last_result  = !eos;

      verdict_rsp              = '0;
      verdict_rsp.item_kind    = KindVerdict;
      verdict_rsp.frame_status = status;
      verdict_rsp.fields_seen  = count_step;
      verdict_rsp.last_result  = 1'b1;

      push        = '0;
      push.second = verdict_rsp;
      if (fld_fire) begin
         push.first = field_rsp;
         push.count = eos ? 2'd2 : 2'd1;
      end else if (accept && eos) begin
         push.first = verdict_rsp;
         push.count = 2'd1;
      end else begin
         push.first = field_rsp;
      end
   end

endmodule

`default_nettype wire

// ===== src/afcp_outq.sv =====
// Result queue: takes up to two results per cycle, hands out one per transaction.
// Depends on afcp_pkg and afcp_if.
`default_nettype none

module afcp_outq (
   input  wire logic          clock,
   input  wire logic          reset,
   input  afcp_pkg::push_type push,
   output logic               room,
   afcp_rsp_if.source         rsp_chan
);
   import afcp_pkg::*;

   localparam int PtrW = $clog2(OutqDepth);
   localparam int CntW = $clog2(OutqDepth + 1);

   rsp_type           slot_ff [OutqDepth];
   logic [PtrW-1:0]   wptr_ff, wptr_in;
   logic [PtrW-1:0]   rptr_ff, rptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              pop;
   logic [PtrW-1:0]   wptr_next;

   assign room           = count_ff <= CntW'(OutqDepth - 2);
   assign rsp_chan.valid = count_ff != '0;
   assign rsp_chan.data  = slot_ff[rptr_ff];
   assign pop            = rsp_chan.valid && rsp_chan.ready;
   assign wptr_next      = wptr_ff + PtrW'(1);

   assign wptr_in  = wptr_ff + PtrW'(push.count);
   assign rptr_in  = rptr_ff + PtrW'(pop);
   assign count_in = count_ff + CntW'(push.count) - CntW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) slot_ff[wptr_ff] <= push.first;
      if (push.count == 2'd2) slot_ff[wptr_next] <= push.second;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(OutqDepth))
      else $error("result queue over capacity");

   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> room)
      else $error("results pushed without room");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |->
         (push.first.item_kind == KindField && push.second.item_kind == KindVerdict
          && !push.first.last_result))
      else $error("result pair out of order");

endmodule

`default_nettype wire
